FILE: hdl/ixsort_pkg.sv
// ----------------------------------------------------------------------------
// ixsort_pkg
// Shared types and constants of the indexed exchange sort: payload structs,
// the command that travels from front to back, and the back-end states.
// ----------------------------------------------------------------------------
`default_nettype none

package ixsort_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int IDX_W     = 6;
	localparam int CNT_W     = 7;
	localparam int VAL_W     = 32;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = 2;
	localparam int QCNT_W    = 3;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic                    is_last;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0]        orig_index;
		logic signed [VAL_W-1:0] sorted_value;
		logic                    overflow;
		logic                    last_out;
	} result_t;

	// one classified input transaction
	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [IDX_W-1:0] slot;
		logic             store;
		logic             is_last;
		logic [CNT_W-1:0] count;
		logic             overflow;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FETCH_P,
		ST_FETCH_VP,
		ST_GET_VP,
		ST_SCAN,
		ST_PUT_P,
		ST_EMIT_A,
		ST_EMIT_B,
		ST_EMIT_C
	} back_state_t;

endpackage

`default_nettype wire

FILE: hdl/ixsort_ram.sv
// ----------------------------------------------------------------------------
// ixsort_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ixsort_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: hdl/ixsort_front.sv
// ----------------------------------------------------------------------------
// ixsort_front
// Input side: accepts items, assigns load slots, tracks the set size and
// the dropped flag, and hands each transaction on as a command.
// ----------------------------------------------------------------------------
`default_nettype none

module ixsort_front
	import ixsort_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	output logic       item_stall,
	input  wire item_t item,
	input  wire logic  q_full,
	output logic       push,
	output cmd_t       push_data
);

	logic [CNT_W-1:0] count_q;
	logic             dropped_q;
	logic             store;

	assign item_stall = q_full;
	assign push       = item_valid && !q_full;
	assign store      = count_q < CNT_W'(MAX_ITEMS);

	always_comb begin
		push_data.value    = item.value;
		push_data.slot     = count_q[IDX_W-1:0];
		push_data.store    = store;
		push_data.is_last  = item.is_last;
		push_data.count    = count_q + CNT_W'(store);
		push_data.overflow = dropped_q || !store;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else if (push) begin
			if (item.is_last) begin
				count_q   <= '0;
				dropped_q <= 1'b0;
			end else begin
				count_q   <= push_data.count;
				dropped_q <= push_data.overflow;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/ixsort_queue.sv
// ----------------------------------------------------------------------------
// ixsort_queue
// Small command FIFO between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module ixsort_queue
	import ixsort_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_data,
	output logic      full,
	input  wire logic pop,
	output cmd_t      pop_data,
	output logic      not_empty
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full      = cnt_q == QCNT_W'(QDEPTH);
	assign not_empty = cnt_q != '0;
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

FILE: hdl/ixsort_back.sv
// ----------------------------------------------------------------------------
// ixsort_back
// Execution side: writes loaded values and identity indices, runs the
// exchange sort on the index RAM with one pipelined comparator, then emits
// the sorted run through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ixsort_back
	import ixsort_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	input  wire cmd_t cmd,
	output logic      cmd_pop,
	output logic      result_valid,
	input  wire logic result_stall,
	output result_t   result
);

	back_state_t state_q, state_d;

	logic [CNT_W-1:0] n_q;
	logic             ovf_q;
	logic [IDX_W-1:0] p_q;
	logic [CNT_W-1:0] qa_q;
	logic [IDX_W-1:0] ip_q;
	logic signed [VAL_W-1:0] vp_q;
	logic [IDX_W-1:0] k_q;
	logic [IDX_W-1:0] eidx_q;

	logic             v1_s1;
	logic [IDX_W-1:0] q1_s1;
	logic             v2_s2;
	logic [IDX_W-1:0] q2_s2;
	logic [IDX_W-1:0] iq_s2;

	result_t res_q;
	logic    res_valid_q;

	logic             idx_we;
	logic [IDX_W-1:0] idx_waddr;
	logic [IDX_W-1:0] idx_wdata;
	logic [IDX_W-1:0] idx_raddr;
	logic [IDX_W-1:0] idx_rdata;
	logic             val_we;
	logic [IDX_W-1:0] val_raddr;
	logic [VAL_W-1:0] val_rdata;

	logic issue;
	logic swap;
	logic res_load;
	logic more_p;
	logic last_k;

	assign issue    = (state_q == ST_SCAN) && (qa_q < n_q);
	assign swap     = (state_q == ST_SCAN) && v2_s2 && ($signed(val_rdata) < vp_q);
	assign res_load = (state_q == ST_EMIT_C) && (!res_valid_q || !result_stall);
	assign more_p   = (CNT_W'(p_q) + CNT_W'(2)) < n_q;
	assign last_k   = (CNT_W'(k_q) + CNT_W'(1)) == n_q;

	assign result_valid = res_valid_q;
	assign result       = res_q;

	ixsort_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ITEMS)) u_index_ram (
		.clk   (clk),
		.we    (idx_we),
		.waddr (idx_waddr),
		.wdata (idx_wdata),
		.raddr (idx_raddr),
		.rdata (idx_rdata)
	);

	ixsort_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ITEMS)) u_value_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (cmd.slot),
		.wdata (cmd.value),
		.raddr (val_raddr),
		.rdata (val_rdata)
	);

	always_comb begin
		state_d   = state_q;
		cmd_pop   = 1'b0;
		idx_we    = 1'b0;
		idx_waddr = cmd.slot;
		idx_wdata = cmd.slot;
		idx_raddr = qa_q[IDX_W-1:0];
		val_we    = 1'b0;
		val_raddr = eidx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					idx_we  = cmd.store;
					val_we  = cmd.store;
					if (cmd.is_last) begin
						state_d = (cmd.count > CNT_W'(1)) ? ST_FETCH_P : ST_EMIT_A;
					end
				end
			end
			ST_FETCH_P: begin
				idx_raddr = p_q;
				state_d   = ST_FETCH_VP;
			end
			ST_FETCH_VP: begin
				val_raddr = idx_rdata;
				state_d   = ST_GET_VP;
			end
			ST_GET_VP: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				val_raddr = idx_rdata;
				// a smaller value moves the running minimum's index out to slot q
				if (swap) begin
					idx_we    = 1'b1;
					idx_waddr = q2_s2;
					idx_wdata = ip_q;
				end
				if (!issue && !v1_s1 && !v2_s2) begin
					state_d = ST_PUT_P;
				end
			end
			ST_PUT_P: begin
				idx_we    = 1'b1;
				idx_waddr = p_q;
				idx_wdata = ip_q;
				state_d   = more_p ? ST_FETCH_P : ST_EMIT_A;
			end
			ST_EMIT_A: begin
				idx_raddr = k_q;
				state_d   = ST_EMIT_B;
			end
			ST_EMIT_B: begin
				val_raddr = idx_rdata;
				state_d   = ST_EMIT_C;
			end
			ST_EMIT_C: begin
				if (res_load) begin
					state_d = last_k ? ST_IDLE : ST_EMIT_A;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			v1_s1       <= 1'b0;
			v2_s2       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v1_s1   <= issue;
			v2_s2   <= v1_s1;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		q1_s1 <= qa_q[IDX_W-1:0];
		q2_s2 <= q1_s1;
		iq_s2 <= idx_rdata;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid && cmd.is_last) begin
					n_q   <= cmd.count;
					ovf_q <= cmd.overflow;
					p_q   <= '0;
					k_q   <= '0;
				end
			end
			ST_FETCH_VP: begin
				ip_q <= idx_rdata;
			end
			ST_GET_VP: begin
				vp_q <= val_rdata;
				qa_q <= CNT_W'(p_q) + CNT_W'(1);
			end
			ST_SCAN: begin
				if (issue) begin
					qa_q <= qa_q + CNT_W'(1);
				end
				if (swap) begin
					ip_q <= iq_s2;
					vp_q <= val_rdata;
				end
			end
			ST_PUT_P: begin
				p_q <= p_q + IDX_W'(1);
				k_q <= '0;
			end
			ST_EMIT_B: begin
				eidx_q <= idx_rdata;
			end
			ST_EMIT_C: begin
				if (res_load) begin
					res_q.orig_index   <= eidx_q;
					res_q.sorted_value <= val_rdata;
					res_q.overflow     <= ovf_q;
					res_q.last_out     <= last_k;
					k_q                <= k_q + IDX_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == ST_EMIT_C)
		else $error("result loaded outside emit");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> (state_q == ST_IDLE) && cmd_valid)
		else $error("command taken while busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> qa_q <= n_q)
		else $error("scan ran past set size");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUT_P) |-> !v1_s1 && !v2_s2)
		else $error("compare pipeline not drained");

endmodule

`default_nettype wire

FILE: hdl/index_exchange_sort.sv
// ----------------------------------------------------------------------------
// index_exchange_sort
// Loads a set of signed values, sorts an index list over them by exchange
// sort, and streams out the sorted run with the original load positions.
// ----------------------------------------------------------------------------
// Items enter one per cycle, while the queue is not full, into a four-entry
// command queue, so the input side keeps taking transactions until the queue
// fills while a previous set is still being sorted or emitted; the back end
// drains one load per cycle while it is idle. Once the item marked last
// arrives, the back end sorts n entries with a single pipelined comparator
// over two simple dual-port RAMs (index and value), n*(n-1)/2 compares in
// all, then streams out the sorted results. Up to 64 values are kept per set;
// further items, the closing one included, are dropped and reported
// through overflow on every result. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module index_exchange_sort
	import ixsort_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	output logic       item_stall,
	input  wire item_t item,
	output logic       result_valid,
	input  wire logic  result_stall,
	output result_t    result
);

	logic q_full;
	logic push;
	cmd_t push_data;
	logic pop;
	cmd_t pop_data;
	logic not_empty;

	ixsort_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_full     (q_full),
		.push       (push),
		.push_data  (push_data)
	);

	ixsort_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (not_empty)
	);

	ixsort_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (not_empty),
		.cmd          (pop_data),
		.cmd_pop      (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire
